// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define AM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/uenc_pkg.sv =====
// shared types, constants and defaults of the url percent encoder
package uenc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_W      = 8;
  localparam int MODE_W      = 2;
  localparam int CAP_W       = 16;
  localparam int OUT_COUNT_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ENCODE_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_CAPACITY = 2'd1;

  // encode modes
  localparam logic [MODE_W-1:0] MODE_SAFE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RFC3986 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HTML5   = 2'd2;

  localparam logic [MODE_W-1:0]  MODE_RESET = MODE_SAFE;
  localparam logic [CAP_W-1:0]   CAP_RESET  = 16'd256;

  localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_NONE    = 8'h00;

  // entry 0 is '0', entry 15 is 'F'
  localparam logic [15:0][BYTE_W-1:0] HEX_DIGITS = "FEDCBA9876543210";

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ESC,
    KIND_DROP
  } uenc_kind_t;

  // classified item handed from front to back
  typedef struct packed {
    uenc_kind_t          kind;
    logic [BYTE_W-1:0]   data;
  } uenc_item_t;

endpackage

// ===== rtl/core/uenc_front.sv =====
// front end: accepts source bytes, classifies them and tracks the string count
`include "assert_macros.svh"

module uenc_front #(
  parameter int COUNT_WIDTH = uenc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [uenc_pkg::MODE_W-1:0]   encode_mode,
  input  logic [uenc_pkg::CAP_W-1:0]    dest_capacity,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [uenc_pkg::BYTE_W-1:0]   src_byte,
  input  logic                          start_string,
  input  logic                          q_full,
  output logic                          push,
  output uenc_pkg::uenc_item_t          push_item,
  output logic [COUNT_WIDTH-1:0]        push_count
);
  import uenc_pkg::*;

  localparam int LW = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 2;

  logic [COUNT_WIDTH-1:0] written_count, written_count_next;
  logic                   stopped, stopped_next;

  logic [COUNT_WIDTH-1:0] wc_eff;
  logic                   st_eff;
  logic [LW-1:0]          lim_raw, lim, cmax, wc_ext;
  logic                   is_alnum, passes, pass_fit, esc_fit;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // limit is capacity minus one, floored at zero and capped by the counter
  always_comb begin
    cmax    = (LW'(1) << COUNT_WIDTH) - LW'(1);
    lim_raw = (dest_capacity == '0) ? '0 : LW'(dest_capacity) - LW'(1);
    lim     = (lim_raw > cmax) ? cmax : lim_raw;
  end

  always_comb begin
    wc_eff = start_string ? '0 : written_count;
    st_eff = start_string ? 1'b0 : stopped;
    wc_ext = LW'(wc_eff);
    pass_fit = wc_ext < lim;
    esc_fit  = (wc_ext + LW'(3)) < lim;
  end

  always_comb begin
    is_alnum = ((src_byte >= 8'h30) && (src_byte <= 8'h39)) ||
               ((src_byte >= 8'h41) && (src_byte <= 8'h5A)) ||
               ((src_byte >= 8'h61) && (src_byte <= 8'h7A));
    passes = is_alnum ||
             (((encode_mode == MODE_RFC3986) || (encode_mode == MODE_HTML5)) &&
              (src_byte == CHAR_DOT)) ||
             ((encode_mode == MODE_HTML5) && (src_byte == CHAR_SPACE));
  end

  always_comb begin
    push_item.data     = src_byte;
    push_item.kind     = KIND_DROP;
    push_count         = wc_eff;
    written_count_next = wc_eff;
    stopped_next       = st_eff;
    if (!st_eff && passes && pass_fit) begin
      push_item.kind     = KIND_PASS;
      push_item.data     = ((encode_mode == MODE_HTML5) && (src_byte == CHAR_SPACE)) ?
                           CHAR_PLUS : src_byte;
      push_count         = wc_eff + COUNT_WIDTH'(1);
      written_count_next = wc_eff + COUNT_WIDTH'(1);
    end else if (!st_eff && !passes && esc_fit) begin
      push_item.kind     = KIND_ESC;
      push_count         = wc_eff + COUNT_WIDTH'(1);
      written_count_next = wc_eff + COUNT_WIDTH'(3);
    end else begin
      stopped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_count <= '0;
      stopped       <= 1'b0;
    end else if (push) begin
      written_count <= written_count_next;
      stopped       <= stopped_next;
    end
  end

  // a dropped byte always leaves the string stopped
  `AM_ASSERT_NXT(a_drop_stops, clk, rst, push && (push_item.kind == KIND_DROP), stopped)

endmodule

// ===== rtl/core/uenc_queue.sv =====
// small register queue between the classifier and the emitter
`include "assert_macros.svh"

module uenc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = uenc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             full
);
  import uenc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_data = slots[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `AM_ASSERT_IMP(a_no_overflow, clk, rst, push && !pop, !full)
  `AM_ASSERT_IMP(a_no_underflow, clk, rst, pop, not_empty)

endmodule

// ===== rtl/core/uenc_back.sv =====
// back end: expands queued items into output characters, one per cycle while the receiver is ready
`include "assert_macros.svh"

module uenc_back #(
  parameter int COUNT_WIDTH = uenc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  uenc_pkg::uenc_item_t              head_item,
  input  logic [COUNT_WIDTH-1:0]            head_count,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [uenc_pkg::BYTE_W-1:0]       out_byte,
  output logic                              byte_valid,
  output logic                              run_last,
  output logic [uenc_pkg::OUT_COUNT_W-1:0]  out_count,
  output logic                              dropped
);
  import uenc_pkg::*;

  logic [1:0]             phase, phase_next;
  logic                   load;
  logic [BYTE_W-1:0]      r_byte;
  logic                   r_bvalid, r_last, r_drop;
  logic [COUNT_WIDTH-1:0] r_count;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && r_last;

  // result for the current phase of the head item
  always_comb begin
    r_byte   = head_item.data;
    r_bvalid = 1'b1;
    r_last   = 1'b1;
    r_drop   = 1'b0;
    r_count  = head_count;
    case (head_item.kind)
      KIND_PASS: begin
        r_byte = head_item.data;
      end
      KIND_ESC: begin
        r_count = head_count + COUNT_WIDTH'(phase);
        r_last  = phase == 2'd2;
        case (phase)
          2'd0:    r_byte = CHAR_PERCENT;
          2'd1:    r_byte = HEX_DIGITS[head_item.data[7:4]];
          default: r_byte = HEX_DIGITS[head_item.data[3:0]];
        endcase
      end
      default: begin
        r_byte   = CHAR_NONE;
        r_bvalid = 1'b0;
        r_drop   = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (load) begin
      phase_next = r_last ? 2'd0 : phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= r_byte;
      byte_valid <= r_bvalid;
      run_last   <= r_last;
      out_count  <= OUT_COUNT_W'(r_count);
      dropped    <= r_drop;
    end
  end

  // mid-escape means an escape item still sits at the queue head
  `AM_ASSERT_IMP(a_phase_on_esc, clk, rst, phase != 2'd0,
                 head_valid && (head_item.kind == KIND_ESC))

endmodule

// ===== rtl/core/url_percent_encoder.sv =====
// path: an accepted byte is written into the queue at the accepting edge, then loaded into the
//   back end output register
// throughput: the back end output register emits one character per cycle while the receiver
//   is ready; a copied or dropped byte gives one result, an escaped byte three
// the front keeps accepting into a QUEUE_DEPTH-entry queue (four by default) while the back end expands escapes
// reset (rst, synchronous, active high) clears count, stop flag, queue and output valid,
//   and loads encode_mode 0 and dest_capacity 256; no clearing pass is needed
module url_percent_encoder #(
  parameter int COUNT_WIDTH = uenc_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = uenc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uenc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [uenc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // source byte channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [uenc_pkg::BYTE_W-1:0]       src_byte,
  input  logic                              start_string,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [uenc_pkg::BYTE_W-1:0]       out_byte,
  output logic                              byte_valid,
  output logic                              run_last,
  output logic [uenc_pkg::OUT_COUNT_W-1:0]  out_count,
  output logic                              dropped
);
  import uenc_pkg::*;

  localparam int ENTRY_W = $bits(uenc_item_t) + COUNT_WIDTH;

  // configuration registers
  logic [MODE_W-1:0] encode_mode;
  logic [CAP_W-1:0]  dest_capacity;

  // front to queue
  logic                   push;
  uenc_item_t             push_item;
  logic [COUNT_WIDTH-1:0] push_count;
  logic                   q_full;

  // queue to back
  logic [ENTRY_W-1:0]     head_data;
  logic                   head_valid;
  uenc_item_t             head_item;
  logic [COUNT_WIDTH-1:0] head_count;
  logic                   pop;

  // config writes are always accepted; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode   <= MODE_RESET;
      dest_capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENCODE_MODE:   encode_mode   <= cfg_data[MODE_W-1:0];
        REG_DEST_CAPACITY: dest_capacity <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // front: classify the byte, decide copy, escape or drop, update the count
  uenc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .encode_mode   (encode_mode),
    .dest_capacity (dest_capacity),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .src_byte      (src_byte),
    .start_string  (start_string),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item),
    .push_count    (push_count)
  );

  // decoupling queue: each entry is the classified item plus its first count
  uenc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_item, push_count}),
    .pop       (pop),
    .head_data (head_data),
    .not_empty (head_valid),
    .full      (q_full)
  );

  assign head_item  = uenc_item_t'(head_data[ENTRY_W-1:COUNT_WIDTH]);
  assign head_count = head_data[COUNT_WIDTH-1:0];

  // back: one output character per transaction, escapes take three
  uenc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_count (head_count),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .out_count  (out_count),
    .dropped    (dropped)
  );

endmodule

// ===== tb/tb_url_percent_encoder.sv =====
// testbench for the url percent encoder: directed and random byte streams checked by a scoreboard

// one expected or observed output character
typedef struct {
  logic [7:0]  chr;
  logic        is_char;
  logic        last;
  logic [15:0] count;
  logic        drop;
} enc_char_t;

class url_scoreboard;
  logic [1:0]  mode;
  logic [15:0] capacity;
  int unsigned written;
  bit          stopped;
  int          fails;
  enc_char_t   pending_chars[$];

  function new();
    mode     = uenc_pkg::MODE_RESET;
    capacity = uenc_pkg::CAP_RESET;
    written  = 0;
    stopped  = 0;
    fails    = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] data);
    if (idx == uenc_pkg::REG_ENCODE_MODE) mode = data[1:0];
    else if (idx == uenc_pkg::REG_DEST_CAPACITY) capacity = data;
  endfunction

  function int pending();
    return pending_chars.size();
  endfunction

  function bit is_plain(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return 1;
    if (b >= 8'h41 && b <= 8'h5A) return 1;
    if (b >= 8'h61 && b <= 8'h7A) return 1;
    if ((mode == uenc_pkg::MODE_RFC3986 || mode == uenc_pkg::MODE_HTML5) &&
        b == uenc_pkg::CHAR_DOT) return 1;
    if (mode == uenc_pkg::MODE_HTML5 && b == uenc_pkg::CHAR_SPACE) return 1;
    return 0;
  endfunction

  function logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + n : 8'h41 + (n - 4'd10);
  endfunction

  function void push(logic [7:0] c, logic v, logic l, logic d);
    enc_char_t e;
    e.chr = c; e.is_char = v; e.last = l; e.count = written[15:0]; e.drop = d;
    pending_chars.push_back(e);
  endfunction

  // accepted source byte: predict its output characters
  function void note_byte(logic [7:0] b, logic start);
    longint unsigned lim;
    longint unsigned cmax;
    logic [7:0]      c;
    if (start) begin
      written = 0;
      stopped = 0;
    end
    cmax = (64'd1 << uenc_pkg::COUNT_WIDTH_DEF) - 1;
    lim  = (capacity == 0) ? 0 : capacity - 1;
    if (lim > cmax) lim = cmax;
    if (!stopped) begin
      if (is_plain(b)) begin
        if (written < lim) begin
          c = (mode == uenc_pkg::MODE_HTML5 && b == uenc_pkg::CHAR_SPACE) ?
              uenc_pkg::CHAR_PLUS : b;
          written++;
          push(c, 1'b1, 1'b1, 1'b0);
          return;
        end
      end else if (written + 3 < lim) begin
        written++;
        push(uenc_pkg::CHAR_PERCENT, 1'b1, 1'b0, 1'b0);
        written++;
        push(hex_char(b[7:4]), 1'b1, 1'b0, 1'b0);
        written++;
        push(hex_char(b[3:0]), 1'b1, 1'b1, 1'b0);
        return;
      end
      stopped = 1;
    end
    push(uenc_pkg::CHAR_NONE, 1'b0, 1'b1, 1'b1);
  endfunction

  function void check_char(enc_char_t got);
    enc_char_t want;
    if (pending_chars.size() == 0) begin
      $error("unexpected output character %02h", got.chr);
      fails++;
      return;
    end
    want = pending_chars.pop_front();
    if (got.chr !== want.chr) begin
      $error("out_byte expected %02h got %02h", want.chr, got.chr);
      fails++;
    end
    if (got.is_char !== want.is_char) begin
      $error("byte_valid expected %0b got %0b", want.is_char, got.is_char);
      fails++;
    end
    if (got.last !== want.last) begin
      $error("run_last expected %0b got %0b", want.last, got.last);
      fails++;
    end
    if (got.count !== want.count) begin
      $error("out_count expected %0d got %0d", want.count, got.count);
      fails++;
    end
    if (got.drop !== want.drop) begin
      $error("dropped expected %0b got %0b", want.drop, got.drop);
      fails++;
    end
  endfunction
endclass

module tb_url_percent_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import uenc_pkg::*;

  // indexes past the register file, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [MODE_W-1:0]      MODE_UNDEF  = 2'd3;

  // the receiver stalls at up to 69 percent; an idle run that reaches STALL_LIMIT
  // means the block has hung
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] src_byte     = '0;
  logic              start_string = 1'b0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [BYTE_W-1:0]      out_byte;
  logic                   byte_valid;
  logic                   run_last;
  logic [OUT_COUNT_W-1:0] out_count;
  logic                   dropped;

  url_scoreboard book = new();

  // idle and stall odds in percent, changed only between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  url_percent_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .src_byte     (src_byte),
    .start_string (start_string),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .out_count    (out_count),
    .dropped      (dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: check every transaction on the result channel, then pick next ready
  initial begin
    enc_char_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.chr = out_byte; got.is_char = byte_valid; got.last = run_last;
        got.count = out_count; got.drop = dropped;
        book.check_char(got);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high between back-to-back calls unless an idle cycle is drawn; drain lowers it
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    src_byte     <= b;
    start_string <= start;
    do @(posedge clk); while (!in_ready);
    book.note_byte(b, start);
  endtask

  task automatic send_str(input string s, input logic start);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], start && (i == 0));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, data);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [15:0] cap);
    write_reg(REG_ENCODE_MODE, {14'd0, mode});
    write_reg(REG_DEST_CAPACITY, cap);
    cfg_valid <= 1'b0;
  endtask

  // every byte yields at least one result, so an empty queue means the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return 8'(8'h61 + $urandom_range(25));   // lower case
    if (pick < 35) return 8'(8'h41 + $urandom_range(25));   // upper case
    if (pick < 47) return 8'(8'h30 + $urandom_range(9));    // digit
    if (pick < 57) return CHAR_DOT;
    if (pick < 67) return CHAR_SPACE;
    return 8'($urandom_range(255, 1));
  endfunction

  initial begin
    logic [1:0]  mode;
    logic [15:0] cap;
    int          sent;
    int          len;
    bit          fresh;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: safe mode, capacity 256; plain classes and escapes
    send_str("Az09", 1'b1);
    send_str(". ", 1'b0);
    send_byte(8'h00, 1'b0);   // zero byte goes out as %00
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();

    // html5 with largest capacity, writes to unused indexes must change nothing
    configure(MODE_HTML5, 16'hFFFF);
    write_reg(REG_SPARE_2, 16'h0001);
    write_reg(REG_SPARE_3, 16'h0000);
    cfg_valid <= 1'b0;
    send_str(" .", 1'b0);
    send_byte(8'h7F, 1'b0);
    drain();

    configure(MODE_RFC3986, 16'hFFFF);
    send_str(". ", 1'b0);
    drain();

    // undefined mode acts as safe mode
    configure(MODE_UNDEF, 16'd64);
    send_str(" .Q", 1'b1);
    drain();

    // zero capacity drops everything
    configure(MODE_SAFE, 16'd0);
    send_str("ab", 1'b1);
    drain();

    // limit 4: an escape fits only at count 0, then one plain byte, then stop
    configure(MODE_SAFE, 16'd5);
    send_str("~abc", 1'b1);
    // escape may not take the last free slots
    send_str("a#", 1'b1);
    drain();

    // random phases cycling through the idle profiles
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      mode = 2'($urandom_range(3));
      if (ph == 2) cap = 16'hFFFF;
      else if (ph == 5) cap = 16'd1;
      else cap = 16'($urandom_range(40, 2));
      configure(mode, cap);
      sent = 0;
      while (sent < 40) begin
        len = $urandom_range(24, 1);
        // a few strings continue the previous one without a start flag
        fresh = ($urandom_range(99) >= 5);
        for (int k = 0; k < len; k++) begin
          send_byte(random_char(), fresh && (k == 0));
          sent++;
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== url_percent_encoder.f =====
+incdir+rtl/core
rtl/core/uenc_pkg.sv
rtl/core/uenc_front.sv
rtl/core/uenc_queue.sv
rtl/core/uenc_back.sv
rtl/core/url_percent_encoder.sv
tb/tb_url_percent_encoder.sv
